FILE: sv/pqt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqt_pkg;

   // default sizes
   localparam int NUM_PROCS_DEF  = 16;
   localparam int NUM_QUEUES_DEF = 8;
   localparam int KEY_BITS_DEF   = 8;

   // fixed field widths
   localparam int KIND_W   = 3;
   localparam int QIDX_W   = 3;
   localparam int PID_W    = 4;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAKE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNLINK = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CREATE = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BADID = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

`default_nettype wire

FILE: sv/process_queue_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Create and rejected beats answer from DISP; unlink goes DISP, UNL_WR; take head goes DISP,
// HEAD_CHK (answering there on an empty queue), UNL_WR; append goes DISP, LNK_WR1, LNK_WR2;
// insert puts WALK_FIRST and WALK (one read per node passed, <= TABLE_SIZE) before LNK_WR1.
// One beat at a time: busy is high from accept until the result strobe cycle, so the next
// beat can be accepted at the edge that ends the strobe. The receiver cannot stall.
// Reset clears queue count and key valid bits; link RAMs are not cleared.
module process_queue_table_core #(
   parameter int NUM_PROCS  = pqt_pkg::NUM_PROCS_DEF,
   parameter int NUM_QUEUES = pqt_pkg::NUM_QUEUES_DEF,
   parameter int KEY_BITS   = pqt_pkg::KEY_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pqt_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [pqt_pkg::QIDX_W-1:0]    req_queue_index,
   input  wire logic [pqt_pkg::PID_W-1:0]     req_process_id,
   input  wire logic [pqt_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                               rsp_valid,
   output logic      [pqt_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [pqt_pkg::PID_W-1:0]     rsp_process_out,
   output logic      [pqt_pkg::QIDX_W-1:0]    rsp_queue_out
);

   // node map: processes 0..NUM_PROCS-1, then head/tail pair per queue
   localparam int TABLE_SIZE = NUM_PROCS + 2 * NUM_QUEUES;
   localparam int NODE_W     = $clog2(TABLE_SIZE);
   localparam int QC_W       = $clog2(NUM_QUEUES + 1);
   localparam int STEP_W     = $clog2(TABLE_SIZE + 1);
   localparam logic [KEY_BITS-1:0] KEY_MASK = '1;

   // sequencer states
   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_DISP       = 4'd1;  // check ids, issue first reads
   localparam logic [3:0] ST_WALK_FIRST = 4'd2;  // first node of list arrives
   localparam logic [3:0] ST_WALK       = 4'd3;  // one node per cycle
   localparam logic [3:0] ST_LNK_WR1    = 4'd4;  // pred arrives, link new node
   localparam logic [3:0] ST_LNK_WR2    = 4'd5;  // patch neighbors
   localparam logic [3:0] ST_HEAD_CHK   = 4'd6;  // first node vs tail
   localparam logic [3:0] ST_UNL_WR     = 4'd7;  // splice neighbors together

   logic [3:0] state_ff, state_in;

   // latched request beat
   logic [pqt_pkg::KIND_W-1:0] kind_ff;
   logic [pqt_pkg::QIDX_W-1:0] q_ff;
   logic [pqt_pkg::PID_W-1:0]  p_ff;
   logic [KEY_BITS-1:0]        key_ff;

   // walk / link working registers
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] succ_ff, succ_in;
   logic [NODE_W-1:0] pred_ff, pred_in;
   logic [NODE_W-1:0] first_ff, first_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   logic [QC_W-1:0]       qc_ff, qc_in;
   logic [TABLE_SIZE-1:0] key_vld_ff, key_vld_in;
   logic                  k_rvld_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pqt_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pqt_pkg::PID_W-1:0]     rsp_proc_ff, rsp_proc_in;
   logic [pqt_pkg::QIDX_W-1:0]    rsp_qout_ff, rsp_qout_in;

   // RAM ports
   logic              n_we, p_we, k_we;
   logic [NODE_W-1:0] n_waddr, p_waddr, k_waddr;
   logic [NODE_W-1:0] n_wdata, p_wdata;
   logic [KEY_BITS-1:0] k_wdata;
   logic [NODE_W-1:0] n_raddr, p_raddr, k_raddr;
   logic [NODE_W-1:0] n_rdata, p_rdata;
   logic [KEY_BITS-1:0] k_rdata;

   // decode helpers
   logic              accept;
   logic              q_bad, p_bad, tbl_full;
   logic [NODE_W-1:0] p_node, head_q, tail_q, head_c, tail_c;
   logic [KEY_BITS-1:0] cur_key;
   logic              key_gt;

   assign accept   = start && (state_ff == ST_IDLE);
   assign q_bad    = int'(q_ff) >= int'(qc_ff);
   assign p_bad    = int'(p_ff) >= NUM_PROCS;
   assign tbl_full = int'(qc_ff) >= NUM_QUEUES;
   assign p_node   = NODE_W'(p_ff);
   assign head_q   = NODE_W'(NUM_PROCS + 2 * int'(q_ff));
   assign tail_q   = NODE_W'(NUM_PROCS + 2 * int'(q_ff) + 1);
   assign head_c   = NODE_W'(NUM_PROCS + 2 * int'(qc_ff));
   assign tail_c   = NODE_W'(NUM_PROCS + 2 * int'(qc_ff) + 1);

   // shared key comparator; a key never written reads as zero
   assign cur_key = k_rvld_ff ? k_rdata : '0;
   assign key_gt  = cur_key > key_ff;

   pqt_ram #(.DEPTH(TABLE_SIZE), .WIDTH(NODE_W), .ADDR_W(NODE_W)) u_next (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   pqt_ram #(.DEPTH(TABLE_SIZE), .WIDTH(NODE_W), .ADDR_W(NODE_W)) u_prev (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   pqt_ram #(.DEPTH(TABLE_SIZE), .WIDTH(KEY_BITS), .ADDR_W(NODE_W)) u_key (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (k_wdata),
      .rd_addr (k_raddr),
      .rd_data (k_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      succ_in       = succ_ff;
      pred_in       = pred_ff;
      first_in      = first_ff;
      steps_in      = steps_ff;
      qc_in         = qc_ff;
      key_vld_in    = key_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = pqt_pkg::STAT_OK;
      rsp_proc_in   = '0;
      rsp_qout_in   = '0;
      n_we = 1'b0;  n_waddr = '0;  n_wdata = '0;  n_raddr = '0;
      p_we = 1'b0;  p_waddr = '0;  p_wdata = '0;  p_raddr = '0;
      k_we = 1'b0;  k_waddr = '0;  k_wdata = '0;  k_raddr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISP;
            end
         end

         ST_DISP: begin
            case (kind_ff)
               pqt_pkg::KIND_APPEND: begin
                  if (q_bad || p_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqt_pkg::STAT_BADID;
                     state_in      = ST_IDLE;
                  end else begin
                     succ_in  = tail_q;
                     p_raddr  = tail_q;
                     state_in = ST_LNK_WR1;
                  end
               end
               pqt_pkg::KIND_INSERT: begin
                  if (q_bad || p_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqt_pkg::STAT_BADID;
                     state_in      = ST_IDLE;
                  end else begin
                     n_raddr  = head_q;
                     state_in = ST_WALK_FIRST;
                  end
               end
               pqt_pkg::KIND_TAKE: begin
                  if (q_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqt_pkg::STAT_BADID;
                     state_in      = ST_IDLE;
                  end else begin
                     n_raddr  = head_q;
                     state_in = ST_HEAD_CHK;
                  end
               end
               pqt_pkg::KIND_UNLINK: begin
                  if (p_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqt_pkg::STAT_BADID;
                     state_in      = ST_IDLE;
                  end else begin
                     n_raddr  = p_node;
                     p_raddr  = p_node;
                     state_in = ST_UNL_WR;
                  end
               end
               pqt_pkg::KIND_CREATE: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (tbl_full) begin
                     rsp_status_in = pqt_pkg::STAT_FULL;
                  end else begin
                     // empty list: head -> tail; tail key zero via valid bit
                     n_we    = 1'b1;
                     n_waddr = head_c;
                     n_wdata = tail_c;
                     p_we    = 1'b1;
                     p_waddr = tail_c;
                     p_wdata = head_c;
                     k_we    = 1'b1;
                     k_waddr = head_c;
                     k_wdata = KEY_MASK;
                     key_vld_in[head_c] = 1'b1;
                     key_vld_in[tail_c] = 1'b0;
                     rsp_qout_in = pqt_pkg::QIDX_W'(qc_ff);
                     qc_in       = qc_ff + 1'b1;
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pqt_pkg::STAT_BADID;
                  state_in      = ST_IDLE;
               end
            endcase
         end

         ST_WALK_FIRST: begin
            cur_in   = n_rdata;
            steps_in = '0;
            n_raddr  = n_rdata;
            k_raddr  = n_rdata;
            state_in = ST_WALK;
         end

         ST_WALK: begin
            // stop at first key not greater, or after a full table of steps
            if (key_gt && (steps_ff != STEP_W'(TABLE_SIZE))) begin
               cur_in   = n_rdata;
               steps_in = steps_ff + 1'b1;
               n_raddr  = n_rdata;
               k_raddr  = n_rdata;
            end else begin
               succ_in  = cur_ff;
               p_raddr  = cur_ff;
               state_in = ST_LNK_WR1;
            end
         end

         ST_LNK_WR1: begin
            pred_in = p_rdata;
            n_we    = 1'b1;
            n_waddr = p_node;
            n_wdata = succ_ff;
            p_we    = 1'b1;
            p_waddr = p_node;
            p_wdata = p_rdata;
            state_in = ST_LNK_WR2;
         end

         ST_LNK_WR2: begin
            n_we    = 1'b1;
            n_waddr = pred_ff;
            n_wdata = p_node;
            p_we    = 1'b1;
            p_waddr = succ_ff;
            p_wdata = p_node;
            if (kind_ff == pqt_pkg::KIND_INSERT) begin
               k_we    = 1'b1;
               k_waddr = p_node;
               k_wdata = key_ff;
               key_vld_in[p_node] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_HEAD_CHK: begin
            if (n_rdata == tail_q) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pqt_pkg::STAT_EMPTY;
               state_in      = ST_IDLE;
            end else begin
               first_in = n_rdata;
               n_raddr  = n_rdata;
               p_raddr  = n_rdata;
               state_in = ST_UNL_WR;
            end
         end

         ST_UNL_WR: begin
            // next[prev] = next; prev[next] = prev
            n_we    = 1'b1;
            n_waddr = p_rdata;
            n_wdata = n_rdata;
            p_we    = 1'b1;
            p_waddr = n_rdata;
            p_wdata = p_rdata;
            if (kind_ff == pqt_pkg::KIND_TAKE) begin
               rsp_proc_in = pqt_pkg::PID_W'(first_ff);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qc_ff        <= '0;
         key_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qc_ff        <= qc_in;
         key_vld_ff   <= key_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         q_ff    <= req_queue_index;
         p_ff    <= req_process_id;
         key_ff  <= KEY_BITS'(req_priority_req);
      end
      cur_ff        <= cur_in;
      succ_ff       <= succ_in;
      pred_ff       <= pred_in;
      first_ff      <= first_in;
      steps_ff      <= steps_in;
      k_rvld_ff     <= key_vld_ff[k_raddr];
      rsp_status_ff <= rsp_status_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_qout_ff   <= rsp_qout_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_process_out = rsp_proc_ff;
   assign rsp_queue_out   = rsp_qout_ff;

   // a result beat only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a preceding busy cycle");

   // the sequencer leaves busy only by issuing a result
   a_busy_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   a_qc_bound: assert property (@(posedge clock) disable iff (reset)
      int'(qc_ff) <= NUM_QUEUES)
      else $error("queue count beyond table size");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (int'(steps_ff) <= TABLE_SIZE))
      else $error("ordered walk ran past the table");

endmodule

`default_nettype wire

FILE: sv/pqt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module pqt_ram #(
   parameter int DEPTH  = pqt_pkg::NUM_PROCS_DEF + 2 * pqt_pkg::NUM_QUEUES_DEF,
   parameter int WIDTH  = pqt_pkg::KEY_BITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
